FILE: sv/bvi_pkg.sv
`default_nettype none
package bvi_pkg;

  localparam int FACTOR_FRAC_BITS_DEF = 28;

  localparam int WORD_W = 32;
  localparam int DIFF_W = 10;
  localparam int PROD_W = DIFF_W + WORD_W;
  localparam int FULL_W = PROD_W + WORD_W;
  localparam int STEP_W = 6;

  // step counts for the shared unit
  localparam logic [STEP_W-1:0] SHORT_STEPS = STEP_W'(DIFF_W);
  localparam logic [STEP_W-1:0] WORD_STEPS  = STEP_W'(WORD_W);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic                  start;
    unit_op_t              op;
    logic [STEP_W-1:0]     steps;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

FILE: sv/bvi_muldiv.sv
`default_nettype none
module bvi_muldiv (
  input  wire                                clk,
  input  wire                                rst,
  input  bvi_pkg::unit_cmd_t                 cmd,
  input  wire        [bvi_pkg::PROD_W-1:0]   op_a,
  input  wire        [bvi_pkg::WORD_W-1:0]   op_b,
  output bvi_pkg::unit_stat_t                stat,
  output logic       [bvi_pkg::FULL_W-1:0]   result
);
  import bvi_pkg::*;

  logic              busy;
  logic              done;
  unit_op_t          op;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] last;
  logic [FULL_W-1:0] acc;
  logic [FULL_W-1:0] mcand;
  logic [WORD_W-1:0] mplier;
  logic [WORD_W-1:0] divisor;

  logic [WORD_W:0]   rem_shift;
  logic [WORD_W:0]   rem_sub;
  logic              fits;
  logic [FULL_W-1:0] acc_next;

  // one restoring division step: remainder in acc[63:32], quotient shifts in at the bottom
  always_comb begin
    rem_shift = {acc[2*WORD_W-1:WORD_W], acc[WORD_W-1]};
    rem_sub   = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
    unique case (op)
      OP_MUL: acc_next = acc + (mplier[0] ? mcand : '0);
      OP_DIV: acc_next = {{(FULL_W-2*WORD_W){1'b0}},
                          (fits ? rem_sub[WORD_W-1:0] : rem_shift[WORD_W-1:0]),
                          acc[WORD_W-2:0], fits};
      default: acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        cnt  <= '0;
        last <= cmd.steps - 1'b1;
        if (cmd.op == OP_MUL) begin
          acc    <= '0;
          mcand  <= {{WORD_W{1'b0}}, op_a};
          mplier <= op_b;
        end else begin
          acc     <= {{(FULL_W-WORD_W){1'b0}}, op_a[WORD_W-1:0]};
          divisor <= op_b;
        end
      end else if (busy) begin
        acc    <= acc_next;
        mcand  <= {mcand[FULL_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[WORD_W-1:1]};
        cnt    <= cnt + 1'b1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

endmodule
`default_nettype wire

FILE: sv/breath_volume_integrator.sv
`default_nettype none
// Breath volume integrator: takes one sensor tick per transaction and returns one result
// per tick. The breath and calibration multiplies and the calibration divide run on a
// single shift-add / restoring-divide unit, one bit per cycle; the average uses two small
// multipliers of its own. The shortest tick has no button held and lies outside the hold
// window; the longest holds breath with calibration ending in the same tick, and runs the
// 10-bit difference times elapsed time, the 32-bit scale by the calibration factor and
// the divide one after another. The calibration product never shares a tick with the
// divide. in_stall is high while a tick is being worked on; the finished result sits in
// an output register, so the next tick can be taken while it waits, and a result still
// waiting there holds the following tick in its last step. Configuration writes must be
// made only between ticks; the block itself does not enforce this. Writing the initial
// factor also loads the working factor.
module breath_volume_integrator #(
  parameter int FACTOR_FRAC_BITS = bvi_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [9:0]  adc_sample,
  input  wire  [9:0]  offset_sample,
  input  wire  [31:0] now_ms,
  input  wire         breath_pressed,
  input  wire         cal_pressed,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] breath_volume,
  output logic        breath_end,
  output logic        cal_end,
  output logic [31:0] cal_factor,
  output logic [17:0] smoothed_level
);
  import bvi_pkg::*;

  localparam int SHIFT = FACTOR_FRAC_BITS - 16;

  localparam logic [1:0] REG_INIT_FACTOR = 2'd0;
  localparam logic [1:0] REG_CAL_REF     = 2'd1;
  localparam logic [1:0] REG_HOLD        = 2'd2;
  localparam logic [1:0] REG_AVG_GAIN    = 2'd3;

  localparam logic [31:0] MAX32         = '1;
  localparam logic [31:0] CAL_REF_RESET = 32'd1127428915;
  localparam logic [15:0] HOLD_RESET    = 16'd750;
  localparam logic [8:0]  EMA_RESET     = 9'd77;
  localparam logic [8:0]  EMA_FULL      = 9'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BREATH,
    S_BMUL1,
    S_BMUL2,
    S_CAL,
    S_CMUL,
    S_CDIV,
    S_CDIVW,
    S_EMA1,
    S_EMA2,
    S_OUT
  } state_t;

  function automatic logic [31:0] add_sat(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  state_t state;

  // configuration
  logic [31:0] cal_reference;
  logic [15:0] hold_ms;
  logic [8:0]  avg_gain;

  // architectural state
  logic [31:0] volume_sum;
  logic [31:0] cal_sum;
  logic [31:0] factor;
  logic [9:0]  offset_level;
  logic [17:0] average;
  logic        prev_breath;
  logic        prev_cal;
  logic [31:0] breath_mark;
  logic [31:0] cal_mark;
  logic [31:0] last_stamp;

  // current tick
  logic [9:0]  cur_sample;
  logic [9:0]  cur_fresh;
  logic [31:0] cur_now;
  logic        cur_breath;
  logic        cur_cal;
  logic [31:0] elapsed;
  logic        b_end;
  logic        c_end;
  logic [26:0] ema_hist;

  // shared unit
  unit_cmd_t         cmd;
  logic [PROD_W-1:0] op_a;
  logic [WORD_W-1:0] op_b;
  unit_stat_t        unit_stat;
  logic [FULL_W-1:0] unit_result;

  bvi_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .op_a   (op_a),
    .op_b   (op_b),
    .stat   (unit_stat),
    .result (unit_result)
  );

  logic        press_edge;
  logic [9:0]  off_eff;
  logic [9:0]  diff;
  logic [31:0] hold_ext;
  logic [31:0] since_breath;
  logic [31:0] since_cal;
  logic [FULL_W-1:0] scaled;
  logic [31:0] scaled_sat;
  logic [31:0] prod_sat;
  logic [8:0]  w_eff;
  logic [8:0]  w_inv;
  logic [26:0] ema_new;
  logic [27:0] ema_sum;

  always_comb begin
    press_edge = (state == S_BREATH) ? (cur_breath && !prev_breath) : (cur_cal && !prev_cal);
    off_eff    = press_edge ? cur_fresh : offset_level;
    diff       = (cur_sample > off_eff) ? (cur_sample - off_eff) : (off_eff - cur_sample);
    hold_ext     = {16'b0, hold_ms};
    since_breath = cur_now - breath_mark;
    since_cal    = cur_now - cal_mark;
    scaled     = unit_result >> SHIFT;
    scaled_sat = (|scaled[FULL_W-1:WORD_W]) ? MAX32 : scaled[WORD_W-1:0];
    prod_sat   = (|unit_result[FULL_W-1:WORD_W]) ? MAX32 : unit_result[WORD_W-1:0];
    w_eff      = (avg_gain > EMA_FULL) ? EMA_FULL : avg_gain;
    w_inv      = EMA_FULL - w_eff;
    ema_new    = 27'(w_eff) * 27'({cur_sample, 8'h00});
    ema_sum    = {1'b0, ema_hist} + {1'b0, ema_new};
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      cmd                <= '0;
      cal_reference      <= CAL_REF_RESET;
      hold_ms            <= HOLD_RESET;
      avg_gain           <= EMA_RESET;
      volume_sum         <= '0;
      cal_sum            <= '0;
      factor             <= '0;
      offset_level       <= '0;
      average            <= '0;
      prev_breath        <= 1'b0;
      prev_cal           <= 1'b0;
      breath_mark        <= '0;
      cal_mark           <= '0;
      last_stamp         <= '0;
      b_end              <= 1'b0;
      c_end              <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_FACTOR: factor       <= cfg_data;
          REG_CAL_REF:    cal_reference <= cfg_data;
          REG_HOLD:       hold_ms       <= cfg_data[15:0];
          REG_AVG_GAIN:   avg_gain      <= cfg_data[8:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_sample <= adc_sample;
            cur_fresh  <= offset_sample;
            cur_now    <= now_ms;
            cur_breath <= breath_pressed;
            cur_cal    <= cal_pressed;
            elapsed    <= now_ms - last_stamp;
            last_stamp <= now_ms;
            state      <= S_BREATH;
          end
        end
        S_BREATH: begin
          if (press_edge) begin
            volume_sum   <= '0;
            breath_mark  <= cur_now;
            offset_level <= cur_fresh;
          end
          b_end       <= !cur_breath && prev_breath && (since_breath > hold_ext);
          prev_breath <= cur_breath;
          if (cur_breath) begin
            cmd   <= '{start: 1'b1, op: OP_MUL, steps: SHORT_STEPS};
            op_a  <= {{DIFF_W{1'b0}}, elapsed};
            op_b  <= {{(WORD_W-DIFF_W){1'b0}}, diff};
            state <= S_BMUL1;
          end else begin
            state <= S_CAL;
          end
        end
        S_BMUL1: begin
          if (unit_stat.done) begin
            cmd   <= '{start: 1'b1, op: OP_MUL, steps: WORD_STEPS};
            op_a  <= unit_result[PROD_W-1:0];
            op_b  <= factor;
            state <= S_BMUL2;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_BMUL2: begin
          cmd.start <= 1'b0;
          if (unit_stat.done) begin
            volume_sum <= add_sat(volume_sum, scaled_sat);
            state      <= S_CAL;
          end
        end
        S_CAL: begin
          if (press_edge) begin
            cal_sum      <= '0;
            cal_mark     <= cur_now;
            offset_level <= cur_fresh;
          end
          // cal_mark only moves on a press, so the old value serves both window tests
          c_end    <= !cur_cal && prev_cal && (since_cal > hold_ext);
          prev_cal <= cur_cal;
          if (cur_cal || (since_cal < hold_ext)) begin
            cmd   <= '{start: 1'b1, op: OP_MUL, steps: SHORT_STEPS};
            op_a  <= {{DIFF_W{1'b0}}, elapsed};
            op_b  <= {{(WORD_W-DIFF_W){1'b0}}, diff};
            state <= S_CMUL;
          end else begin
            state <= S_CDIV;
          end
        end
        S_CMUL: begin
          cmd.start <= 1'b0;
          if (unit_stat.done) begin
            cal_sum <= add_sat(cal_sum, prod_sat);
            state   <= S_CDIV;
          end
        end
        S_CDIV: begin
          priority if (!c_end) begin
            state <= S_EMA1;
          end else if (cal_sum == '0) begin
            factor <= MAX32;
            state  <= S_EMA1;
          end else begin
            cmd   <= '{start: 1'b1, op: OP_DIV, steps: WORD_STEPS};
            op_a  <= {{DIFF_W{1'b0}}, cal_reference};
            op_b  <= cal_sum;
            state <= S_CDIVW;
          end
        end
        S_CDIVW: begin
          cmd.start <= 1'b0;
          if (unit_stat.done) begin
            factor <= unit_result[WORD_W-1:0];
            state  <= S_EMA1;
          end
        end
        S_EMA1: begin
          ema_hist <= 27'(w_inv) * 27'(average);
          state    <= S_EMA2;
        end
        S_EMA2: begin
          average <= ema_sum[25:8];
          state   <= S_OUT;
        end
        S_OUT: begin
          // hold the result here until the output register is free
          if (!out_valid || !out_stall) begin
            breath_volume  <= volume_sum;
            breath_end     <= b_end;
            cal_end        <= c_end;
            cal_factor     <= factor;
            smoothed_level <= average;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a transaction without going busy");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !unit_stat.busy)
    else $error("shared unit still busy while sequencer idle");

  a_factor_source: assert property (@(posedge clk) disable iff (rst)
    !$stable(factor) |-> ($past(rst) || $past(cfg_we) || $past(state == S_CDIV) ||
                          $past(state == S_CDIVW)))
    else $error("calibration factor changed without a write or calibration end");

endmodule
`default_nettype wire

FILE: dv/bvi_tb_pkg.sv
package bvi_tb_pkg;

  // register map of the configuration port
  typedef enum logic [1:0] {
    REG_INIT_FACTOR,
    REG_CAL_REFERENCE,
    REG_HOLD_MS,
    REG_AVG_GAIN
  } cfg_reg_t;

  localparam logic [31:0] CAL_REFERENCE_RESET = 32'd1127428915;
  localparam logic [15:0] HOLD_MS_RESET       = 16'd750;
  localparam logic [8:0]  AVG_GAIN_RESET      = 9'd77;

endpackage

FILE: dv/bvi_checker.sv
module bvi_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [9:0]  adc_sample,
  input  wire  [9:0]  offset_sample,
  input  wire  [31:0] now_ms,
  input  wire         breath_pressed,
  input  wire         cal_pressed,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [31:0] breath_volume,
  input  wire         breath_end,
  input  wire         cal_end,
  input  wire  [31:0] cal_factor,
  input  wire  [17:0] smoothed_level,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bvi_tb_pkg::*;

  localparam int SCALE_SHIFT = bvi_pkg::FACTOR_FRAC_BITS_DEF - 16;

  typedef struct packed {
    logic [31:0] volume;
    logic        breath_done;
    logic        cal_done;
    logic [31:0] factor;
    logic [17:0] level;
  } tick_result_t;

  tick_result_t due_results[$];
  int fail_count = 0;

  // predictor copy of registers and state
  logic [31:0] cfg_reference;
  logic [15:0] cfg_hold;
  logic [8:0]  cfg_weight;
  logic [31:0] vol_acc, cal_acc, cur_factor, last_ms, breath_t0, cal_t0;
  logic [9:0]  zero_level;
  logic [17:0] ema;
  logic        breath_was, cal_was;

  assign errors = fail_count;

  function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [9:0] level_gap(logic [9:0] a, logic [9:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    if (fail_count < 40)
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    logic [31:0]  gap_ms, w;
    logic [41:0]  prod;
    logic [79:0]  wide;
    logic [63:0]  mix;
    tick_result_t want, got;
    if (rst) begin
      cfg_reference   = CAL_REFERENCE_RESET;
      cfg_hold        = HOLD_MS_RESET;
      cfg_weight      = AVG_GAIN_RESET;
      vol_acc = '0; cal_acc = '0; cur_factor = '0; last_ms = '0;
      breath_t0 = '0; cal_t0 = '0; zero_level = '0; ema = '0;
      breath_was = 1'b0; cal_was = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_FACTOR:   cur_factor = cfg_data;
          REG_CAL_REFERENCE: cfg_reference = cfg_data;
          REG_HOLD_MS:       cfg_hold = cfg_data[15:0];
          REG_AVG_GAIN:      cfg_weight = cfg_data[8:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report("result with nothing outstanding", breath_volume, '0);
        end else begin
          want = due_results.pop_front();
          if (breath_volume !== want.volume) report("breath_volume", breath_volume, want.volume);
          if (breath_end !== want.breath_done) report("breath_end", breath_end, want.breath_done);
          if (cal_end !== want.cal_done) report("cal_end", cal_end, want.cal_done);
          if (cal_factor !== want.factor) report("cal_factor", cal_factor, want.factor);
          if (smoothed_level !== want.level) report("smoothed_level", smoothed_level, want.level);
        end
      end

      if (in_valid && !in_stall) begin
        gap_ms = now_ms - last_ms;
        last_ms = now_ms;
        got = '0;

        if (breath_pressed && !breath_was) begin
          vol_acc = '0;
          breath_t0 = now_ms;
          zero_level = offset_sample;
        end
        if (breath_pressed) begin
          prod = 42'(level_gap(adc_sample, zero_level)) * 42'(gap_ms);
          wide = (80'(prod) * 80'(cur_factor)) >> SCALE_SHIFT;
          vol_acc = add_sat32(vol_acc, (wide > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0]);
        end
        if (!breath_pressed && breath_was && (now_ms - breath_t0) > 32'(cfg_hold))
          got.breath_done = 1'b1;
        breath_was = breath_pressed;

        // a calibration press recaptures the offset after the breath part used it
        if (cal_pressed && !cal_was) begin
          cal_acc = '0;
          cal_t0 = now_ms;
          zero_level = offset_sample;
        end
        if (cal_pressed || (now_ms - cal_t0) < 32'(cfg_hold)) begin
          prod = 42'(level_gap(adc_sample, zero_level)) * 42'(gap_ms);
          cal_acc = add_sat32(cal_acc, (prod > 42'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0]);
        end
        if (!cal_pressed && cal_was && (now_ms - cal_t0) > 32'(cfg_hold)) begin
          cur_factor = (cal_acc == '0) ? 32'hFFFF_FFFF : cfg_reference / cal_acc;
          got.cal_done = 1'b1;
        end
        cal_was = cal_pressed;

        w = (cfg_weight > 9'd256) ? 32'd256 : 32'(cfg_weight);
        mix = (64'(32'd256 - w) * 64'(ema) + 64'(w) * (64'(adc_sample) << 8)) >> 8;
        ema = mix[17:0];

        got.volume = vol_acc;
        got.factor = cur_factor;
        got.level  = ema;
        due_results.push_back(got);
      end
    end
    pending <= due_results.size();
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bvi_tb_pkg::*;

  localparam int FIRST_SWAP  = 530;
  localparam int SECOND_SWAP = 1060;
  localparam int LONG_HOLD_AT = 1250;
  localparam int LONG_HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [9:0]  adc_sample = '0;
  logic [9:0]  offset_sample = '0;
  logic [31:0] now_ms = '0;
  logic        breath_pressed = 1'b0;
  logic        cal_pressed = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall, out_valid, breath_end, cal_end;
  wire  [31:0] breath_volume, cal_factor;
  wire  [17:0] smoothed_level;
  int          errors, pending;

  int          send_idle_pct = 30;
  int          recv_idle_pct = 80;
  int          sent = 0;
  int          accepted = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int          hold_cur = 750;
  logic [31:0] clock_ms = '0;

  breath_volume_integrator uut (.*);
  bvi_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // receiver side; one long hold-off lets the block fill up and stall its input
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) accepted <= accepted + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && accepted == LONG_HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_tick(input logic [9:0] smp, input logic [9:0] fresh,
                           input logic [31:0] stamp, input logic bp, input logic cp);
    int gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= smp;
    offset_sample <= fresh;
    now_ms <= stamp;
    breath_pressed <= bp;
    cal_pressed <= cp;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent == FIRST_SWAP) begin
      send_idle_pct = 80;
      recv_idle_pct <= 30;
    end else if (sent == SECOND_SWAP) begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] init_f, input logic [31:0] cal_ref,
                               input logic [15:0] hold_v, input logic [8:0] weight_v);
    write_reg(REG_INIT_FACTOR, init_f);
    write_reg(REG_CAL_REFERENCE, cal_ref);
    write_reg(REG_HOLD_MS, 32'(hold_v));
    write_reg(REG_AVG_GAIN, 32'(weight_v));
    cfg_we <= 1'b0;
    hold_cur = hold_v;
  endtask

  // tick spacing scales with the hold window so sessions end on both sides of it
  function automatic logic [31:0] step_ms();
    return $urandom_range(hold_cur / 12 + 30, 1);
  endfunction

  function automatic logic [9:0] near_level(input int zero, input int spread);
    int v;
    v = zero + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic run_session();
    int kind, len, zero, spread, tail;
    logic bp, cp, cp_now;
    kind = $urandom_range(99);
    len = $urandom_range(40, 1);
    zero = $urandom_range(1023);
    spread = ($urandom_range(9) == 0) ? 0 : $urandom_range(1023, 1);
    tail = $urandom_range(3, 1);
    if (kind < 8) begin
      // noise: arbitrary fields and time jumps
      clock_ms = ($urandom_range(3) == 0) ? $urandom() : clock_ms + step_ms();
      send_tick(10'($urandom_range(1023)), 10'($urandom_range(1023)), clock_ms,
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      bp = (kind < 55) || (kind >= 85);
      cp = (kind >= 55);
      for (int i = 0; i < len; i++) begin
        clock_ms = clock_ms + step_ms();
        cp_now = cp && !(kind >= 85 && i > len / 2 && $urandom_range(1) == 1);
        send_tick(near_level(zero, spread), (i == 0) ? 10'(zero) : 10'($urandom_range(1023)),
                  clock_ms, bp, cp_now);
      end
      for (int i = 0; i < tail; i++) begin
        clock_ms = ($urandom_range(9) == 0) ? clock_ms + $urandom() : clock_ms + step_ms();
        send_tick(near_level(zero, spread), 10'($urandom_range(1023)), clock_ms, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic random_phase(input int count);
    int target;
    target = sent + count;
    while (sent < target) run_session();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_settings(32'h1000_0000, CAL_REFERENCE_RESET, HOLD_MS_RESET, AVG_GAIN_RESET);

    // directed: field extremes, short and long presses, zero sum, wrap, saturation
    send_tick(10'd0,    10'd0,    32'd0,    1'b0, 1'b0);
    send_tick(10'd1023, 10'd0,    32'd25,   1'b0, 1'b0);
    send_tick(10'd1023, 10'd0,    32'd50,   1'b1, 1'b0);
    send_tick(10'd0,    10'd555,  32'd75,   1'b1, 1'b0);
    send_tick(10'd300,  10'd0,    32'd100,  1'b0, 1'b0);
    send_tick(10'd1023, 10'd1023, 32'd125,  1'b1, 1'b0);
    send_tick(10'd0,    10'd12,   32'd1000, 1'b1, 1'b0);
    send_tick(10'd0,    10'd0,    32'd1000, 1'b0, 1'b0);
    send_tick(10'd512,  10'd512,  32'd1100, 1'b0, 1'b1);
    send_tick(10'd512,  10'd7,    32'd1200, 1'b0, 1'b1);
    send_tick(10'd512,  10'd900,  32'd2000, 1'b0, 1'b0);
    send_tick(10'd1023, 10'd0,    32'd2025, 1'b1, 1'b0);
    send_tick(10'd1023, 10'd0,    32'hFFFF_FFF0, 1'b1, 1'b0);
    send_tick(10'd1023, 10'd0,    32'h0000_0010, 1'b0, 1'b0);
    send_tick(10'd700,  10'd300,  32'h0000_0020, 1'b0, 1'b1);
    send_tick(10'd100,  10'd0,    32'h0000_0040, 1'b0, 1'b0);
    send_tick(10'd1023, 10'd0,    32'h0000_0100, 1'b0, 1'b0);
    send_tick(10'd600,  10'd0,    32'h0000_0400, 1'b0, 1'b0);
    send_tick(10'd900,  10'd100,  32'h0000_0500, 1'b1, 1'b1);
    send_tick(10'd20,   10'd1023, 32'h0000_0600, 1'b1, 1'b1);
    send_tick(10'd400,  10'd0,    32'h0000_0900, 1'b0, 1'b0);
    send_tick(10'd1023, 10'd0,    32'h0000_1000, 1'b0, 1'b1);
    send_tick(10'd1023, 10'd0,    32'hF000_0000, 1'b0, 1'b1);
    send_tick(10'd1023, 10'd0,    32'hF000_1000, 1'b0, 1'b0);
    clock_ms = 32'hF000_1000;
    drain_results();

    random_phase(380);
    drain_results();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 9'd256);
    random_phase(400);
    drain_results();
    load_settings(32'h0, 32'h0, 16'h0, 9'd0);
    random_phase(400);
    drain_results();
    // weight above 1.0 in Q1.8 gets clamped
    load_settings($urandom(), $urandom(), 16'($urandom_range(2000)),
                  9'($urandom_range(511, 257)));
    random_phase(400);
    drain_results();
    repeat (120) @(posedge clk);

    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
